/* sv/arp_cache_with_learning_macros.svh */
// ----------------------------------------------------------------------------
// ARP cache assertion macros
// Concurrent assertion wrappers, empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ARP_CACHE_WITH_LEARNING_MACROS_SVH
`define ARP_CACHE_WITH_LEARNING_MACROS_SVH
`ifndef SYNTHESIS
`define ARPC_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define ARPC_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define ARPC_ASSERT_IMP(label, clk, rst_n, a, c)
`define ARPC_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

/* sv/arpc_pkg.sv */
// ----------------------------------------------------------------------------
// ARP cache package
// Shared types and constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package arpc_pkg;
  localparam logic [1:0]  OP_POLL = 2'd0;
  localparam logic [1:0]  OP_LOOKUP = 2'd1;
  localparam logic [1:0]  OP_PACKET = 2'd2;
  localparam logic [15:0] MIN_PACKET_LEN = 16'd28;
  localparam logic [15:0] HW_ETHERNET = 16'd1;
  localparam logic [15:0] PROTO_IPV4 = 16'h0800;
  localparam logic [15:0] OPCODE_REQUEST = 16'd1;
  localparam logic [31:0] RESET_TIMEOUT_MS = 32'd60000;
  localparam logic [0:0]  CFG_TIMEOUT = 1'b0;
  localparam logic [0:0]  CFG_OWN_ADDR = 1'b1;

  typedef enum logic [1:0] {
    CMD_POLL,
    CMD_LOOKUP,
    CMD_LEARN
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] now_ms;
    logic [31:0] addr;
    logic [47:0] hw_addr;
    logic        reply;
  } cmd_t;
endpackage

/* sv/arpc_front.sv */
// ----------------------------------------------------------------------------
// ARP cache front end
// Accept items, check packets, queue commands for the table engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module arpc_front import arpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_now_ms,
  input  logic [31:0] in_query_address,
  input  logic [47:0] in_sender_hw_address,
  input  logic [31:0] in_request_target_address,
  input  logic [15:0] in_hardware_kind,
  input  logic [15:0] in_protocol_kind,
  input  logic [15:0] in_arp_operation,
  input  logic [15:0] in_packet_length,
  input  logic [31:0] own_addr,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output cmd_t        cmd
);
  cmd_t       q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, rp_r;
  cmd_t       c;
  logic       ok, push, pop;

  always_comb begin
    ok = (in_packet_length >= MIN_PACKET_LEN) && (in_hardware_kind == HW_ETHERNET)
      && (in_protocol_kind == PROTO_IPV4);
    c.now_ms = in_now_ms;
    c.addr = in_query_address;
    c.hw_addr = in_sender_hw_address;
    c.reply = (in_arp_operation == OPCODE_REQUEST)
      && (in_request_target_address == own_addr);
    case (in_op)
      OP_LOOKUP: c.kind = CMD_LOOKUP;
      OP_PACKET: c.kind = ok ? CMD_LEARN : CMD_POLL;
      default:   c.kind = CMD_POLL;
    endcase
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push = in_valid && in_ready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop = cmd_valid && cmd_ready;
  assign cmd = q_r[rp_r];
  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
    end
    if (push) q_r[wp_r] <= c;
  end
endmodule

/* sv/arpc_engine.sv */
// ----------------------------------------------------------------------------
// ARP cache table engine
// Scan the table per command: age, match, free and oldest search, write back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "arp_cache_with_learning_macros.svh"
module arpc_engine import arpc_pkg::*; #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] timeout,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic [47:0] out_found_hw_address,
  output logic        out_packet_accepted,
  output logic        out_send_reply,
  output logic [47:0] out_reply_dest_hw_address,
  output logic [31:0] out_reply_dest_address
);
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [TABLE_ENTRIES-1:0] vld_r;
  logic [31:0] pa_r [TABLE_ENTRIES];
  logic [47:0] hw_r [TABLE_ENTRIES];
  logic [31:0] ls_r [TABLE_ENTRIES];

  logic [1:0]    st_r;
  logic [CW-1:0] i_r;
  cmd_t          c_r;
  logic          hit_r, free_r;
  logic [IW-1:0] hit_idx_r, free_idx_r, old_idx_r;
  logic [31:0]   old_ts_r;
  logic [47:0]   hit_hw_r;
  logic          ov_r;
  logic          of_r, opa_r, osr_r;
  logic [47:0]   ofh_r, orh_r;
  logic [31:0]   ora_r;

  logic [IW-1:0] idx, slot;
  logic          alive, match;
  logic [31:0]   age;
  logic          fire;

  assign idx = i_r[IW-1:0];
  assign age = c_r.now_ms - ls_r[idx];
  assign alive = vld_r[idx] && (age < timeout);
  assign match = alive && (pa_r[idx] == c_r.addr);
  assign cmd_ready = (st_r == S_IDLE);
  assign slot = hit_r ? hit_idx_r : (free_r ? free_idx_r : old_idx_r);
  assign fire = (st_r == S_DONE) && (!ov_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      vld_r <= '0;
      ov_r <= 1'b0;
      i_r <= '0;
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
        ls_r[k] <= '0;
        pa_r[k] <= '0;
        hw_r[k] <= '0;
      end
    end else begin
      if (fire) ov_r <= 1'b1;
      else if (ov_r && out_ready) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (cmd_valid) begin
            c_r <= cmd;
            i_r <= '0;
            hit_r <= 1'b0;
            free_r <= 1'b0;
            old_idx_r <= '0;
            old_ts_r <= ls_r[0];
            st_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          vld_r[idx] <= alive;
          if (match && !hit_r) begin
            hit_r <= 1'b1;
            hit_idx_r <= idx;
            hit_hw_r <= hw_r[idx];
          end
          if (!alive && !free_r) begin
            free_r <= 1'b1;
            free_idx_r <= idx;
          end
          if (ls_r[idx] < old_ts_r) begin
            old_ts_r <= ls_r[idx];
            old_idx_r <= idx;
          end
          if (i_r == CW'(TABLE_ENTRIES - 1)) st_r <= S_DONE;
          i_r <= i_r + 1'b1;
        end
        S_DONE: begin
          if (fire) begin
            if (c_r.kind == CMD_LEARN) begin
              vld_r[slot] <= 1'b1;
              pa_r[slot] <= c_r.addr;
              hw_r[slot] <= c_r.hw_addr;
              ls_r[slot] <= c_r.now_ms;
            end
            of_r <= (c_r.kind == CMD_LOOKUP) && hit_r;
            ofh_r <= ((c_r.kind == CMD_LOOKUP) && hit_r) ? hit_hw_r : '0;
            opa_r <= (c_r.kind == CMD_LEARN);
            osr_r <= (c_r.kind == CMD_LEARN) && c_r.reply;
            orh_r <= ((c_r.kind == CMD_LEARN) && c_r.reply) ? c_r.hw_addr : '0;
            ora_r <= ((c_r.kind == CMD_LEARN) && c_r.reply) ? c_r.addr : '0;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = ov_r;
  assign out_found = of_r;
  assign out_found_hw_address = ofh_r;
  assign out_packet_accepted = opa_r;
  assign out_send_reply = osr_r;
  assign out_reply_dest_hw_address = orh_r;
  assign out_reply_dest_address = ora_r;

  `ARPC_ASSERT_NXT(a_accept_scan, clk, rst_n, cmd_valid && cmd_ready, st_r == S_SCAN)
  `ARPC_ASSERT_IMP(a_reply_learn, clk, rst_n, ov_r && osr_r, opa_r)
  `ARPC_ASSERT_IMP(a_found_lone, clk, rst_n, ov_r && of_r, !opa_r)
endmodule

/* sv/arp_cache_with_learning.sv */
// ----------------------------------------------------------------------------
// ARP cache with learning
// The table engine takes one item at a time: it accepts it when idle, scans
// every entry in turn for aging and searches, then writes back and dispatches
// the result; a two-entry queue lets the front end take items while it works.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module arp_cache_with_learning import arpc_pkg::*; #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_now_ms,
  input  logic [31:0] in_query_address,
  input  logic [47:0] in_sender_hw_address,
  input  logic [31:0] in_request_target_address,
  input  logic [15:0] in_hardware_kind,
  input  logic [15:0] in_protocol_kind,
  input  logic [15:0] in_arp_operation,
  input  logic [15:0] in_packet_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic [47:0] out_found_hw_address,
  output logic        out_packet_accepted,
  output logic        out_send_reply,
  output logic [47:0] out_reply_dest_hw_address,
  output logic [31:0] out_reply_dest_address
);
  logic [31:0] timeout_r, own_r;
  logic        cmd_valid, cmd_ready;
  cmd_t        cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= RESET_TIMEOUT_MS;
      own_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TIMEOUT:  timeout_r <= cfg_data;
        CFG_OWN_ADDR: own_r <= cfg_data;
        default: ;
      endcase
    end
  end

  arpc_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_op, .in_now_ms, .in_query_address,
    .in_sender_hw_address, .in_request_target_address, .in_hardware_kind,
    .in_protocol_kind, .in_arp_operation, .in_packet_length,
    .own_addr(own_r), .cmd_valid, .cmd_ready, .cmd
  );

  arpc_engine #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_engine (
    .clk, .rst_n, .timeout(timeout_r), .cmd_valid, .cmd_ready, .cmd,
    .out_valid, .out_ready, .out_found, .out_found_hw_address,
    .out_packet_accepted, .out_send_reply, .out_reply_dest_hw_address,
    .out_reply_dest_address
  );
endmodule
